### sv/gql_pkg.sv
package gql_pkg;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_PLACE = 2'd2;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OUTLINE   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLOR     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_INV_WIDTH = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_INV_HEIGHT = 3'd4;

    localparam logic [7:0] CHAR_TAB     = 8'd9;
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;

    typedef struct packed {
        logic [1:0]         mode;
        logic [7:0]         char_code;
        logic signed [11:0] offset_x;
        logic signed [11:0] offset_y;
        logic [11:0]        glyph_width;
        logic [11:0]        glyph_height;
        logic signed [11:0] advance;
        logic [11:0]        atlas_x;
        logic [11:0]        atlas_y;
        logic signed [23:0] start_x;
        logic signed [23:0] start_y;
    } t_item;

    typedef struct packed {
        logic signed [23:0] vert_x;
        logic signed [23:0] vert_y;
        logic [15:0]        tex_u;
        logic [15:0]        tex_v;
        logic [15:0]        vert_outline;
        logic [31:0]        vert_color;
        logic               quad_last;
    } t_vert;

    typedef struct packed {
        logic [11:0]        glyph_height;
        logic [11:0]        glyph_width;
        logic signed [11:0] offset_y;
        logic signed [11:0] offset_x;
    } t_glyph_box;

    typedef struct packed {
        logic [11:0]        atlas_y;
        logic [11:0]        atlas_x;
        logic signed [11:0] advance;
    } t_glyph_place;

    typedef struct packed {
        logic [15:0] scale;
        logic [15:0] outline_thickness;
        logic [31:0] text_color;
        logic [23:0] inv_atlas_width;
        logic [23:0] inv_atlas_height;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         mode;
        logic [7:0]         char_code;
        logic signed [23:0] start_x;
        logic signed [23:0] start_y;
    } t_ctrl;

    typedef struct packed {
        t_ctrl              ctrl;
        logic               visible;
        logic signed [28:0] p_offx;
        logic signed [28:0] p_offy;
        logic signed [28:0] p_adv;
        logic [27:0]        p_w;
        logic [27:0]        p_h;
        logic [35:0]        tu1;
        logic [36:0]        tu2;
        logic [35:0]        tv1;
        logic [36:0]        tv2;
    } t_prod;

    typedef struct packed {
        logic signed [23:0] x_a;
        logic signed [23:0] x_b;
        logic signed [23:0] y_a;
        logic signed [23:0] y_b;
        logic [15:0]        u1;
        logic [15:0]        u2;
        logic [15:0]        v1;
        logic [15:0]        v2;
    } t_quad;

endpackage

### sv/gql_item_if.sv
interface gql_item_if;
    import gql_pkg::*;

    logic  valid;
    logic  ready;
    t_item data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

### sv/gql_vert_if.sv
interface gql_vert_if;
    import gql_pkg::*;

    logic  valid;
    logic  ready;
    t_vert data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

### sv/gql_glyph_mem.sv
module gql_glyph_mem #(
    parameter int GLYPH_ENTRIES = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic                  i_rd_en,
    input  logic [7:0]            i_code,
    input  gql_pkg::t_glyph_box   i_wr_box,
    input  gql_pkg::t_glyph_place i_wr_place,
    output gql_pkg::t_glyph_box   o_rd_box,
    output gql_pkg::t_glyph_place o_rd_place
);
    import gql_pkg::*;

    localparam int AW = $clog2(GLYPH_ENTRIES);

    t_glyph_box         r_box_mem   [GLYPH_ENTRIES];
    t_glyph_place       r_place_mem [GLYPH_ENTRIES];
    logic [GLYPH_ENTRIES-1:0] r_entry_valid;
    t_glyph_box         r_rd_box;
    t_glyph_place       r_rd_place;
    logic               r_rd_hit;
    logic               in_range;
    logic [AW-1:0]      addr;

    assign in_range = {1'b0, i_code} < 9'(GLYPH_ENTRIES);
    assign addr     = i_code[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_wr_en && in_range) begin
            r_box_mem[addr]   <= i_wr_box;
            r_place_mem[addr] <= i_wr_place;
        end
        if (i_rd_en) begin
            r_rd_box   <= r_box_mem[addr];
            r_rd_place <= r_place_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_valid <= '0;
            r_rd_hit      <= 1'b0;
        end else begin
            if (i_wr_en && in_range) begin
                r_entry_valid[addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_hit <= in_range && r_entry_valid[addr];
            end
        end
    end

    // An entry never loaded, or a code beyond the table, reads as an empty glyph.
    assign o_rd_box   = r_rd_hit ? r_rd_box : '0;
    assign o_rd_place = r_rd_hit ? r_rd_place : '0;
endmodule

### sv/gql_mul.sv
module gql_mul (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  gql_pkg::t_cfg         i_cfg,
    input  logic                  i_take,
    input  gql_pkg::t_ctrl        i_ctrl,
    input  gql_pkg::t_glyph_box   i_box,
    input  gql_pkg::t_glyph_place i_place,
    input  logic                  i_p_free,
    output logic                  o_ready,
    output logic                  o_p_valid,
    output gql_pkg::t_prod        o_prod
);
    import gql_pkg::*;

    logic               r_valid;
    t_ctrl              r_ctrl;
    logic               r_p_valid;
    t_prod              r_prod;
    t_prod              n_prod;
    logic               go;
    logic signed [16:0] sc_s;
    logic [12:0]        ax_w;
    logic [12:0]        ay_h;

    assign go      = r_valid && i_p_free;
    assign o_ready = !r_valid || i_p_free;
    assign sc_s    = $signed({1'b0, i_cfg.scale});
    assign ax_w    = 13'(i_place.atlas_x) + 13'(i_box.glyph_width);
    assign ay_h    = 13'(i_place.atlas_y) + 13'(i_box.glyph_height);

    always_comb begin
        n_prod.ctrl    = r_ctrl;
        n_prod.visible = (i_box.glyph_width != '0) && (i_box.glyph_height != '0) &&
                         (i_cfg.scale != '0);
        n_prod.p_offx  = 29'(i_box.offset_x) * 29'(sc_s);
        n_prod.p_offy  = 29'(i_box.offset_y) * 29'(sc_s);
        n_prod.p_adv   = 29'(i_place.advance) * 29'(sc_s);
        n_prod.p_w     = 28'(i_box.glyph_width) * 28'(i_cfg.scale);
        n_prod.p_h     = 28'(i_box.glyph_height) * 28'(i_cfg.scale);
        n_prod.tu1     = 36'(i_place.atlas_x) * 36'(i_cfg.inv_atlas_width);
        n_prod.tu2     = 37'(ax_w) * 37'(i_cfg.inv_atlas_width);
        n_prod.tv1     = 36'(i_place.atlas_y) * 36'(i_cfg.inv_atlas_height);
        n_prod.tv2     = 37'(ay_h) * 37'(i_cfg.inv_atlas_height);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_p_valid <= 1'b0;
        end else begin
            if (i_take) begin
                r_valid <= 1'b1;
            end else if (go) begin
                r_valid <= 1'b0;
            end
            if (go) begin
                r_p_valid <= 1'b1;
            end else if (i_p_free) begin
                r_p_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_ctrl <= i_ctrl;
        end
        if (go) begin
            r_prod <= n_prod;
        end
    end

    assign o_p_valid = r_p_valid;
    assign o_prod    = r_prod;
endmodule

### sv/gql_pen.sv
module gql_pen (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [15:0]    i_scale,
    input  logic           i_p_valid,
    input  gql_pkg::t_prod i_prod,
    input  logic           i_emit_free,
    output logic           o_p_free,
    output logic           o_quad_valid,
    output gql_pkg::t_quad o_quad
);
    import gql_pkg::*;

    localparam logic [1:0] IDX_AFTER_NEWLINE = 2'd1;

    function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
        logic signed [23:0] r;
        if (v > 32'sd8388607) begin
            r = 24'sh7FFFFF;
        end else if (v < -32'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

    function automatic logic [15:0] texc(input logic [37:0] p);
        logic [37:0] s;
        logic [15:0] r;
        s = p + 38'd128;
        r = (s[37:24] != '0) ? 16'hFFFF : s[23:8];
        return r;
    endfunction

    logic signed [23:0] r_pen_x;
    logic signed [23:0] r_pen_y;
    logic signed [23:0] r_line_x;
    logic [1:0]         r_idx;
    logic signed [23:0] n_pen_x;
    logic signed [23:0] n_pen_y;
    logic signed [23:0] n_line_x;
    logic [1:0]         n_idx;

    logic               emit;
    logic               go;
    logic [21:0]        sc28;
    logic [21:0]        sc38;
    logic [22:0]        tab_amt;
    logic [1:0]         idx_next;
    logic signed [23:0] pen_adv;
    logic signed [31:0] gx;
    logic signed [31:0] gx2;
    logic signed [31:0] gy;
    logic signed [31:0] gy2;

    assign sc28     = (22'(i_scale) << 5) - (22'(i_scale) << 2);
    assign sc38     = (22'(i_scale) << 5) + (22'(i_scale) << 2) + (22'(i_scale) << 1);
    assign idx_next = r_idx + 2'd1;

    always_comb begin
        unique case (idx_next)
            2'd0:    tab_amt = '0;
            2'd1:    tab_amt = 23'(sc28);
            2'd2:    tab_amt = 23'(sc28) << 1;
            default: tab_amt = 23'(sc28) + (23'(sc28) << 1);
        endcase
    end

    assign emit = i_p_valid && (i_prod.ctrl.mode == MODE_PLACE) &&
                  (i_prod.ctrl.char_code != CHAR_NEWLINE) &&
                  (i_prod.ctrl.char_code != CHAR_TAB) && i_prod.visible;
    assign go       = i_p_valid && (!emit || i_emit_free);
    assign o_p_free = !i_p_valid || go;

    assign pen_adv = sat24(32'(r_pen_x) + 32'(i_prod.p_adv));
    assign gx      = 32'(r_pen_x) + 32'(i_prod.p_offx);
    assign gx2     = gx + $signed(32'(i_prod.p_w));
    assign gy      = -32'(r_pen_y) - 32'(i_prod.p_offy);
    assign gy2     = gy - $signed(32'(i_prod.p_h));

    always_comb begin
        n_pen_x  = r_pen_x;
        n_pen_y  = r_pen_y;
        n_line_x = r_line_x;
        n_idx    = r_idx;
        if (i_prod.ctrl.mode == MODE_START) begin
            n_pen_x  = i_prod.ctrl.start_x;
            n_pen_y  = i_prod.ctrl.start_y;
            n_line_x = i_prod.ctrl.start_x;
            n_idx    = '0;
        end else if (i_prod.ctrl.mode == MODE_PLACE) begin
            if (i_prod.ctrl.char_code == CHAR_NEWLINE) begin
                n_pen_y = sat24(32'(r_pen_y) + $signed(32'(sc38)));
                n_pen_x = r_line_x;
                n_idx   = IDX_AFTER_NEWLINE;
            end else if (i_prod.ctrl.char_code == CHAR_TAB) begin
                n_pen_x = sat24(32'(pen_adv) + $signed(32'(tab_amt)));
                n_idx   = idx_next;
            end else begin
                n_pen_x = pen_adv;
                n_idx   = idx_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_x  <= '0;
            r_pen_y  <= '0;
            r_line_x <= '0;
            r_idx    <= '0;
        end else if (go) begin
            r_pen_x  <= n_pen_x;
            r_pen_y  <= n_pen_y;
            r_line_x <= n_line_x;
            r_idx    <= n_idx;
        end
    end

    assign o_quad_valid = go && emit;
    assign o_quad.x_a   = sat24(gx);
    assign o_quad.x_b   = sat24(gx2);
    assign o_quad.y_a   = sat24(gy);
    assign o_quad.y_b   = sat24(gy2);
    assign o_quad.u1    = texc(38'(i_prod.tu1));
    assign o_quad.u2    = texc(38'(i_prod.tu2));
    assign o_quad.v1    = texc(38'(i_prod.tv1));
    assign o_quad.v2    = texc(38'(i_prod.tv2));
endmodule

### sv/gql_emit.sv
module gql_emit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  gql_pkg::t_cfg  i_cfg,
    input  logic           i_quad_valid,
    input  gql_pkg::t_quad i_quad,
    output logic           o_free,
    output logic           o_valid,
    input  logic           i_ready,
    output gql_pkg::t_vert o_vert
);
    import gql_pkg::*;

    localparam logic [1:0] VTX_FIRST = 2'd0;
    localparam logic [1:0] VTX_LAST  = 2'd3;

    logic       r_valid;
    logic [1:0] r_vtx;
    t_quad      r_quad;

    assign o_free = !r_valid || (i_ready && (r_vtx == VTX_LAST));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_vtx   <= VTX_FIRST;
        end else if (i_quad_valid) begin
            r_valid <= 1'b1;
            r_vtx   <= VTX_FIRST;
        end else if (r_valid && i_ready) begin
            if (r_vtx == VTX_LAST) begin
                r_valid <= 1'b0;
            end
            r_vtx <= r_vtx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_quad_valid) begin
            r_quad <= i_quad;
        end
    end

    // Corners go top left, bottom left, bottom right, top right.
    always_comb begin
        o_vert.vert_outline = i_cfg.outline_thickness;
        o_vert.vert_color   = i_cfg.text_color;
        o_vert.quad_last    = (r_vtx == VTX_LAST);
        unique case (r_vtx)
            2'd0: begin
                o_vert.vert_x = r_quad.x_a;
                o_vert.vert_y = r_quad.y_a;
                o_vert.tex_u  = r_quad.u1;
                o_vert.tex_v  = r_quad.v1;
            end
            2'd1: begin
                o_vert.vert_x = r_quad.x_a;
                o_vert.vert_y = r_quad.y_b;
                o_vert.tex_u  = r_quad.u1;
                o_vert.tex_v  = r_quad.v2;
            end
            2'd2: begin
                o_vert.vert_x = r_quad.x_b;
                o_vert.vert_y = r_quad.y_b;
                o_vert.tex_u  = r_quad.u2;
                o_vert.tex_v  = r_quad.v2;
            end
            default: begin
                o_vert.vert_x = r_quad.x_b;
                o_vert.vert_y = r_quad.y_a;
                o_vert.tex_u  = r_quad.u2;
                o_vert.tex_v  = r_quad.v1;
            end
        endcase
    end

    assign o_valid = r_valid;
endmodule

### sv/glyph_quad_layout.sv
// Channel   Dir  Modport  Beat
// i_item    in   sink     one load, start or place command
// o_vert    out  source   one quad corner, quad_last on the fourth
// i_cfg_*   in   -        register write, no handshake
//
// Commands flow through a glyph memory read, a multiply stage and a pen stage,
// one per cycle unless o_vert stalls. A visible glyph holds the vertex stage
// for its four corners, one beat per cycle while o_vert.ready is high; other
// commands pass it no quad. The products and the quad are each registered.
// Reset is synchronous and clears the glyph valid bits and the pen at once.
// A stall on o_vert backs up through the stages into i_item.ready.
module glyph_quad_layout #(
    parameter int GLYPH_ENTRIES = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    gql_item_if.sink                          i_item,
    gql_vert_if.source                        o_vert,
    input  logic                              i_cfg_we,
    input  logic [gql_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [gql_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import gql_pkg::*;

    t_cfg         r_cfg;
    logic         accept;
    logic         take;
    logic         mul_ready;
    logic         p_valid;
    logic         p_free;
    logic         emit_free;
    logic         quad_valid;
    t_prod        prod;
    t_quad        quad;
    t_ctrl        ctrl;
    t_glyph_box   wr_box;
    t_glyph_place wr_place;
    t_glyph_box   rd_box;
    t_glyph_place rd_place;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scale             <= 16'd256;
            r_cfg.outline_thickness <= '0;
            r_cfg.text_color        <= 32'hFFFF_FFFF;
            r_cfg.inv_atlas_width   <= 24'd4096;
            r_cfg.inv_atlas_height  <= 24'd4096;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SCALE:      r_cfg.scale             <= i_cfg_data[15:0];
                CFG_OUTLINE:    r_cfg.outline_thickness <= i_cfg_data[15:0];
                CFG_COLOR:      r_cfg.text_color        <= i_cfg_data;
                CFG_INV_WIDTH:  r_cfg.inv_atlas_width   <= i_cfg_data[23:0];
                CFG_INV_HEIGHT: r_cfg.inv_atlas_height  <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    assign i_item.ready = mul_ready;
    assign accept       = i_item.valid && mul_ready;
    assign take         = accept && ((i_item.data.mode == MODE_START) ||
                                     (i_item.data.mode == MODE_PLACE));

    assign ctrl.mode      = i_item.data.mode;
    assign ctrl.char_code = i_item.data.char_code;
    assign ctrl.start_x   = i_item.data.start_x;
    assign ctrl.start_y   = i_item.data.start_y;

    assign wr_box.offset_x     = i_item.data.offset_x;
    assign wr_box.offset_y     = i_item.data.offset_y;
    assign wr_box.glyph_width  = i_item.data.glyph_width;
    assign wr_box.glyph_height = i_item.data.glyph_height;
    assign wr_place.advance    = i_item.data.advance;
    assign wr_place.atlas_x    = i_item.data.atlas_x;
    assign wr_place.atlas_y    = i_item.data.atlas_y;

    gql_glyph_mem #(
        .GLYPH_ENTRIES(GLYPH_ENTRIES)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (accept && (i_item.data.mode == MODE_LOAD)),
        .i_rd_en    (accept && (i_item.data.mode == MODE_PLACE)),
        .i_code     (i_item.data.char_code),
        .i_wr_box   (wr_box),
        .i_wr_place (wr_place),
        .o_rd_box   (rd_box),
        .o_rd_place (rd_place)
    );

    gql_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_take    (take),
        .i_ctrl    (ctrl),
        .i_box     (rd_box),
        .i_place   (rd_place),
        .i_p_free  (p_free),
        .o_ready   (mul_ready),
        .o_p_valid (p_valid),
        .o_prod    (prod)
    );

    gql_pen u_pen (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_scale      (r_cfg.scale),
        .i_p_valid    (p_valid),
        .i_prod       (prod),
        .i_emit_free  (emit_free),
        .o_p_free     (p_free),
        .o_quad_valid (quad_valid),
        .o_quad       (quad)
    );

    gql_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_quad_valid (quad_valid),
        .i_quad       (quad),
        .o_free       (emit_free),
        .o_valid      (o_vert.valid),
        .i_ready      (o_vert.ready),
        .o_vert       (o_vert.data)
    );
endmodule
